// File: rtl/cbf_pkg.sv
// cbf_pkg: shared constants, register codes and controller/datapath signal groups
// for the cubic bezier flattener. No dependencies.
`default_nettype none

package cbf_pkg;

    localparam int MAX_DEPTH_DEF   = 6;
    localparam int FRAC_BITS_DEF   = 5;
    localparam int COORD_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_H = 1'b1;
    localparam logic [CFG_W-1:0] AREA_W_RST = 15'd640;
    localparam logic [CFG_W-1:0] AREA_H_RST = 15'd480;

    // which hull cross product the multipliers or the subtractor work on
    typedef enum logic [1:0] {
        XS_A,
        XS_B,
        XS_D
    } t_xsel;

    typedef struct packed {
        logic  load_in;
        logic  init;
        logic  diff;
        logic  mul_en;
        t_xsel mul_sel;
        logic  sub_en;
        t_xsel sub_sel;
        logic  sum;
        logic  split;
        logic  emit;
        logic  pop;
    } t_dp_cmd;

    typedef struct packed {
        logic reject;
        logic flat;
        logic depth_hit;
        logic sp_zero;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/cubic_bezier_flatten.sv
// cubic_bezier_flatten: top level, sequencer plus datapath.
// Depends on cbf_pkg, cbf_ctrl, cbf_datapath.
//
//   channel  direction  handshake                   word
//   in       input      i_in_valid / o_in_ready     four control points
//   out      output     o_out_valid / i_out_ready   one chord segment
//   cfg      input      i_cfg_we, no wait           area width or height
//
// One curve is worked at a time. After the accept and box test, each
// subdivision and each emitted segment runs the hull area test; a segment
// at the depth limit skips it. The two shared multipliers do the three hull
// cross products in turn. Reset is synchronous and returns the area
// registers to 640 x 480. A stalled output holds the sequencer in place.
`default_nettype none

module cubic_bezier_flatten
    import cbf_pkg::*;
#(
    parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_W-1:0]              i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_ctrl1_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_ctrl1_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_ctrl2_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_ctrl2_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0]      o_seg_from_x,
    output logic signed [COORD_WIDTH-1:0]      o_seg_from_y,
    output logic signed [COORD_WIDTH-1:0]      o_seg_to_x,
    output logic signed [COORD_WIDTH-1:0]      o_seg_to_y,
    output logic                               o_last_segment
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cbf_datapath #(
        .MAX_DEPTH   (MAX_DEPTH),
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_ctrl1_x      (i_ctrl1_x),
        .i_ctrl1_y      (i_ctrl1_y),
        .i_ctrl2_x      (i_ctrl2_x),
        .i_ctrl2_y      (i_ctrl2_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_seg_from_x   (o_seg_from_x),
        .o_seg_from_y   (o_seg_from_y),
        .o_seg_to_x     (o_seg_to_x),
        .o_seg_to_y     (o_seg_to_y),
        .o_last_segment (o_last_segment)
    );

endmodule

`default_nettype wire

// File: rtl/cbf_ctrl.sv
// cbf_ctrl: sequencer for the bezier flattener, drives datapath commands.
// Depends on cbf_pkg.
`default_nettype none

module cbf_ctrl
    import cbf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_MA,
        S_MB,
        S_MD,
        S_SD,
        S_SUM,
        S_TEST,
        S_EMIT,
        S_POP
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.reject) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                // at the depth limit the chord goes out whatever the area
                if (i_stat.depth_hit) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.diff = 1'b1;
                    n_state    = S_MA;
                end
            end
            S_MA: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = XS_A;
                n_state       = S_MB;
            end
            S_MB: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = XS_B;
                o_cmd.sub_en  = 1'b1;
                o_cmd.sub_sel = XS_A;
                n_state       = S_MD;
            end
            S_MD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = XS_D;
                o_cmd.sub_en  = 1'b1;
                o_cmd.sub_sel = XS_B;
                n_state       = S_SD;
            end
            S_SD: begin
                o_cmd.sub_en  = 1'b1;
                o_cmd.sub_sel = XS_D;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_TEST;
            end
            S_TEST: begin
                if (i_stat.flat) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.split = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.sp_zero ? S_IDLE : S_POP;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_EVAL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

`default_nettype wire

// File: rtl/cbf_datapath.sv
// cbf_datapath: coordinate registers, sub-curve stack, hull area unit,
// midpoint split and output register. Depends on cbf_pkg.
`default_nettype none

module cbf_datapath
    import cbf_pkg::*;
#(
    parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_stat                           o_stat,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_W-1:0]              i_cfg_wdata,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_ctrl1_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_ctrl1_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_ctrl2_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_ctrl2_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0]      o_seg_from_x,
    output logic signed [COORD_WIDTH-1:0]      o_seg_from_y,
    output logic signed [COORD_WIDTH-1:0]      o_seg_to_x,
    output logic signed [COORD_WIDTH-1:0]      o_seg_to_y,
    output logic                               o_last_segment
);

    localparam int FW   = COORD_WIDTH + FRAC_BITS;   // fixed coordinate
    localparam int DW   = FW + 1;                    // hull edge vector
    localparam int PW   = 2 * DW;                    // product
    localparam int XW   = PW + 1;                    // cross product
    localparam int SW   = XW + 1;                    // area sum
    localparam int EW   = FW + 3;                    // split sums
    localparam int LW   = $clog2(MAX_DEPTH + 1);
    localparam int SAW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CMPW = ((COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W) + 1;
    localparam longint AREA_LIM_I = 64'sd1 <<< (2 * FRAC_BITS - 1);
    localparam logic signed [SW-1:0] AREA_LIM  = SW'(AREA_LIM_I);
    localparam logic signed [SW-1:0] AREA_NLIM = SW'(-AREA_LIM_I);
    localparam logic [LW-1:0] LVL_MAX = LW'(MAX_DEPTH);

    typedef logic signed [FW-1:0] t_fix;
    typedef logic signed [EW-1:0] t_ext;
    typedef logic signed [DW-1:0] t_vec;

    // configuration
    logic [CFG_W-1:0] r_area_w, r_area_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_w <= AREA_W_RST;
            r_area_h <= AREA_H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_AREA_W: r_area_w <= i_cfg_wdata;
                REG_AREA_H: r_area_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // captured control points, x at even places
    logic signed [COORD_WIDTH-1:0] r_in [8];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in[0] <= i_start_x;
            r_in[1] <= i_start_y;
            r_in[2] <= i_ctrl1_x;
            r_in[3] <= i_ctrl1_y;
            r_in[4] <= i_ctrl2_x;
            r_in[5] <= i_ctrl2_y;
            r_in[6] <= i_end_x;
            r_in[7] <= i_end_y;
        end
    end

    // box is off the area when all x (or y) are negative or all at or past the edge
    logic rej_x_neg, rej_y_neg, rej_x_hi, rej_y_hi;

    always_comb begin
        logic signed [CMPW-1:0] lim_w, lim_h;
        lim_w     = $signed({{(CMPW - CFG_W){1'b0}}, r_area_w});
        lim_h     = $signed({{(CMPW - CFG_W){1'b0}}, r_area_h});
        rej_x_neg = 1'b1;
        rej_y_neg = 1'b1;
        rej_x_hi  = 1'b1;
        rej_y_hi  = 1'b1;
        for (int i = 0; i < 4; i++) begin
            rej_x_neg = rej_x_neg & r_in[2*i][COORD_WIDTH-1];
            rej_y_neg = rej_y_neg & r_in[2*i+1][COORD_WIDTH-1];
            rej_x_hi  = rej_x_hi & (CMPW'(r_in[2*i]) >= lim_w);
            rej_y_hi  = rej_y_hi & (CMPW'(r_in[2*i+1]) >= lim_h);
        end
    end

    // current sub-curve and stack of pending right halves
    t_fix            r_cur [8];
    logic [LW-1:0]   r_lvl;
    logic [LW-1:0]   r_sp;
    t_fix            r_stk_c [MAX_DEPTH][8];
    logic [LW-1:0]   r_stk_l [MAX_DEPTH];

    logic [SAW-1:0]  push_addr, pop_addr;
    assign push_addr = r_sp[SAW-1:0];
    assign pop_addr  = SAW'(r_sp - LW'(1));

    // midpoint split, one axis per lane
    t_fix left_c [8];
    t_fix right_c [8];

    always_comb begin
        t_ext ea, eb, ec, ed, s_mid, s_l2, s_r1, s_l1, s_r2;
        for (int k = 0; k < 2; k++) begin
            ea    = EW'(r_cur[k]);
            eb    = EW'(r_cur[2+k]);
            ec    = EW'(r_cur[4+k]);
            ed    = EW'(r_cur[6+k]);
            s_mid = ea + (eb <<< 1) + eb + (ec <<< 1) + ec + ed;
            s_l1  = ea + eb;
            s_l2  = ea + (eb <<< 1) + ec;
            s_r1  = eb + (ec <<< 1) + ed;
            s_r2  = ec + ed;
            left_c[k]    = r_cur[k];
            left_c[2+k]  = FW'(s_l1 >>> 1);
            left_c[4+k]  = FW'(s_l2 >>> 2);
            left_c[6+k]  = FW'(s_mid >>> 3);
            right_c[k]   = FW'(s_mid >>> 3);
            right_c[2+k] = FW'(s_r1 >>> 2);
            right_c[4+k] = FW'(s_r2 >>> 1);
            right_c[6+k] = r_cur[6+k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.split) begin
            r_stk_c[push_addr] <= right_c;
            r_stk_l[push_addr] <= r_lvl + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            for (int i = 0; i < 8; i++) begin
                // c * 2^FRAC_BITS plus one half
                r_cur[i] <= {r_in[i], 1'b1, {(FRAC_BITS - 1){1'b0}}};
            end
            r_lvl <= '0;
        end else if (i_cmd.split) begin
            r_cur <= left_c;
            r_lvl <= r_lvl + LW'(1);
        end else if (i_cmd.pop) begin
            r_cur <= r_stk_c[pop_addr];
            r_lvl <= r_stk_l[pop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.init) begin
            r_sp <= '0;
        end else if (i_cmd.split) begin
            r_sp <= r_sp + LW'(1);
        end else if (i_cmd.pop) begin
            r_sp <= r_sp - LW'(1);
        end
    end

    // hull area: edge vectors, two shared multipliers, then the cross products
    t_vec r_v1x, r_v1y, r_v2x, r_v2y, r_v3x, r_v3y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_v1x <= DW'(r_cur[2]) - DW'(r_cur[0]);
            r_v1y <= DW'(r_cur[3]) - DW'(r_cur[1]);
            r_v2x <= DW'(r_cur[4]) - DW'(r_cur[0]);
            r_v2y <= DW'(r_cur[5]) - DW'(r_cur[1]);
            r_v3x <= DW'(r_cur[6]) - DW'(r_cur[0]);
            r_v3y <= DW'(r_cur[7]) - DW'(r_cur[1]);
        end
    end

    t_vec m0a, m0b, m1a, m1b;

    always_comb begin
        unique case (i_cmd.mul_sel)
            XS_A: begin
                m0a = r_v3x; m0b = r_v2y; m1a = r_v2x; m1b = r_v3y;
            end
            XS_B: begin
                m0a = r_v3x; m0b = r_v1y; m1a = r_v1x; m1b = r_v3y;
            end
            XS_D: begin
                m0a = r_v2x; m0b = r_v1y; m1a = r_v1x; m1b = r_v2y;
            end
            default: begin
                m0a = '0; m0b = '0; m1a = '0; m1b = '0;
            end
        endcase
    end

    logic signed [PW-1:0] r_p0, r_p1;
    logic signed [XW-1:0] r_xa, r_xb, r_xd;
    logic signed [XW-1:0] xdiff;

    assign xdiff = XW'(r_p0) - XW'(r_p1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_p0 <= m0a * m0b;
            r_p1 <= m1a * m1b;
        end
        if (i_cmd.sub_en) begin
            unique case (i_cmd.sub_sel)
                XS_A:    r_xa <= xdiff;
                XS_B:    r_xb <= xdiff;
                XS_D:    r_xd <= xdiff;
                default: ;
            endcase
        end
    end

    // sign class of the three cross products picks the hull area terms
    logic signed [SW-1:0] r_sum;
    logic                 r_neg;
    logic [2:0]           code;
    logic signed [SW-1:0] sum_n;

    assign code = {r_xa[XW-1], r_xb[XW-1], r_xd[XW-1]};

    always_comb begin
        unique case (code)
            3'd1, 3'd6: sum_n = SW'(r_xb) - SW'(r_xd);
            3'd3, 3'd4: sum_n = SW'(r_xa) - SW'(r_xb);
            default:    sum_n = SW'(r_xa) + SW'(r_xd);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum <= sum_n;
            r_neg <= code[2];
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_seg_from_x   <= COORD_WIDTH'(r_cur[0] >>> FRAC_BITS);
            o_seg_from_y   <= COORD_WIDTH'(r_cur[1] >>> FRAC_BITS);
            o_seg_to_x     <= COORD_WIDTH'(r_cur[6] >>> FRAC_BITS);
            o_seg_to_y     <= COORD_WIDTH'(r_cur[7] >>> FRAC_BITS);
            o_last_segment <= (r_sp == '0);
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_stat.reject    = rej_x_neg | rej_y_neg | rej_x_hi | rej_y_hi;
        o_stat.flat      = r_neg ? (r_sum > AREA_NLIM) : (r_sum < AREA_LIM);
        o_stat.depth_hit = (r_lvl >= LVL_MAX);
        o_stat.sp_zero   = (r_sp == '0);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire

// File: rtl/cbf_checker.sv
// cbf_checker: port-level properties of the bezier flattener, bound to the
// top level. Depends on cbf_pkg and cubic_bezier_flatten.
`default_nettype none

module cbf_checker
    import cbf_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic signed [COORD_WIDTH-1:0] o_seg_from_x,
    input wire logic signed [COORD_WIDTH-1:0] o_seg_from_y,
    input wire logic signed [COORD_WIDTH-1:0] o_seg_to_x,
    input wire logic signed [COORD_WIDTH-1:0] o_seg_to_y,
    input wire logic                          o_last_segment
);

    // a stalled segment word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_seg_from_x)
            && $stable(o_seg_from_y) && $stable(o_seg_to_x) && $stable(o_seg_to_y)
            && $stable(o_last_segment))
        else $error("segment word changed while stalled");

    // once ready for a new curve, only the final segment may still wait
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_last_segment)
        else $error("non-final segment pending while ready for a curve");

    // an accepted curve closes the input in the cycle after the accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

endmodule

bind cubic_bezier_flatten cbf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cbf_checker (.*);

`default_nettype wire
